[hdl/iads_pkg.sv]
// Shared types and constants for the indexed array insert/delete/search block.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package iads_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = 6;
    localparam int STAT_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_DUMP   = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BADINDEX  = 3'd3,
        ST_NOTFOUND  = 3'd4,
        ST_BADCMD    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_CNT_M1,
        PTR_POS_P1,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_UP,
        WR_DOWN,
        WR_VALUE
    } t_wr_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        t_ptr_op ptr_op;
        logic    rd_en;
        t_wr_op  wr_op;
        t_cnt_op cnt_op;
        logic    emit;
        t_status emit_status;
        logic    emit_last;
        logic    emit_rd_idx;
        logic    emit_rd_data;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic cnt_zero;
        logic cnt_full;
        logic pos_gt_cnt;
        logic pos_eq_cnt;
        logic pos_ge_cnt;
        logic pos_p1_eq_cnt;
        logic ptr_eq_pos;
        logic ptr_eq_cnt_m1;
        logic rd_valid;
        logic rd_match;
        logic rd_last;
    } t_dp_stat;

endpackage

[hdl/indexed_array_insert_delete_search.sv]
// Top level of the ordered-list block: controller plus datapath.
// Depends on iads_pkg, iads_ctrl, iads_dp (and through it iads_ram).
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// --------  ---------  ----------------------  --------------------------------------
// command   in         start high, busy low    i_command, i_value, i_position
// result    out        o_strobe, one cycle     o_status, o_found_index, o_data, o_last
//
// Busy rises after the accepting edge and covers the decode state plus the walk through
// the RAM, one entry per cycle, for a search or dump (a search ends early on a match), an
// insert at p < n or a delete at p < n - 1. Clear, errors, empty cases and deleting the
// last entry finish in the decode state; an insert at the end goes on to the value write.
// A dump streams one result per cycle; the final result has o_last set and busy is
// already low in that cycle. Reset is synchronous, active low, empties the list and needs
// no clearing pass. The receiver cannot stall.

module indexed_array_insert_delete_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [iads_pkg::CMD_W-1:0]         i_command,
    input  logic signed [iads_pkg::DATA_W-1:0] i_value,
    input  logic [iads_pkg::POS_W-1:0]         i_position,
    output logic                               o_strobe,
    output logic [iads_pkg::STAT_W-1:0]        o_status,
    output logic [iads_pkg::IDX_W-1:0]         o_found_index,
    output logic signed [iads_pkg::DATA_W-1:0] o_data,
    output logic                               o_last
);
    import iads_pkg::*;

    // The controller only sees status flags; all entry data stays in the datapath.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    iads_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_stat (dp_stat),
        .o_cmd  (dp_cmd)
    );

    // Shifts are pipelined: the entry read in one cycle is written one slot up or
    // down in the next while the following read is issued.
    iads_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_command    (i_command),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_found_index(o_found_index),
        .o_data       (o_data),
        .o_last       (o_last)
    );

endmodule

[hdl/iads_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; depends on nothing else.
`timescale 1ns / 1ps

module iads_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/iads_dp.sv]
// Datapath: latched item, entry count, scan pointer, entry RAM and result registers.
// Depends on iads_pkg and iads_ram.
`timescale 1ns / 1ps

module iads_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  iads_pkg::t_dp_cmd               i_cmd,
    output iads_pkg::t_dp_stat              o_stat,
    input  logic [iads_pkg::CMD_W-1:0]      i_command,
    input  logic signed [iads_pkg::DATA_W-1:0] i_value,
    input  logic [iads_pkg::POS_W-1:0]      i_position,
    output logic                            o_strobe,
    output logic [iads_pkg::STAT_W-1:0]     o_status,
    output logic [iads_pkg::IDX_W-1:0]      o_found_index,
    output logic signed [iads_pkg::DATA_W-1:0] o_data,
    output logic                            o_last
);
    import iads_pkg::*;

    logic [CMD_W-1:0]         r_cmd;
    logic signed [DATA_W-1:0] r_value;
    logic [POS_W-1:0]         r_pos;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [IDX_W-1:0]         r_ptr;
    logic [IDX_W-1:0]         n_ptr;
    logic                     r_rv;
    logic [IDX_W-1:0]         r_ra;
    logic [CNT_W-1:0]         cnt_m1;
    logic [DATA_W-1:0]        rdata;
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic [DATA_W-1:0]        wdata;

    logic                     r_strobe;
    logic [STAT_W-1:0]        r_status;
    logic [IDX_W-1:0]         r_idx;
    logic signed [DATA_W-1:0] r_data;
    logic                     r_last;

    assign cnt_m1 = r_count - CNT_W'(1);

    always_comb begin
        case (i_cmd.ptr_op)
            PTR_CNT_M1: n_ptr = cnt_m1[IDX_W-1:0];
            PTR_POS_P1: n_ptr = r_pos[IDX_W-1:0] + IDX_W'(1);
            PTR_ZERO:   n_ptr = '0;
            PTR_INC:    n_ptr = r_ptr + IDX_W'(1);
            PTR_DEC:    n_ptr = r_ptr - IDX_W'(1);
            default:    n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_CLR: n_count = '0;
            CNT_INC: n_count = r_count + CNT_W'(1);
            CNT_DEC: n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    // Shift writes use the data read in the previous cycle.
    always_comb begin
        we    = 1'b1;
        waddr = r_ra;
        wdata = rdata;
        case (i_cmd.wr_op)
            WR_UP:    waddr = r_ra + IDX_W'(1);
            WR_DOWN:  waddr = r_ra - IDX_W'(1);
            WR_VALUE: begin
                waddr = r_pos[IDX_W-1:0];
                wdata = r_value;
            end
            default:  we = 1'b0;
        endcase
    end

    iads_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (i_cmd.rd_en),
        .i_raddr(r_ptr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rv     <= i_cmd.rd_en;
            r_strobe <= i_cmd.emit;
        end
        if (i_cmd.capture) begin
            r_cmd   <= i_command;
            r_value <= i_value;
            r_pos   <= i_position;
        end
        r_ptr <= n_ptr;
        if (i_cmd.rd_en) begin
            r_ra <= r_ptr;
        end
        if (i_cmd.emit) begin
            r_status <= i_cmd.emit_status;
            r_idx    <= i_cmd.emit_rd_idx ? r_ra : '0;
            r_data   <= i_cmd.emit_rd_data ? $signed(rdata) : '0;
            r_last   <= i_cmd.emit_last;
        end
    end

    always_comb begin
        o_stat.cmd           = t_cmd'(r_cmd);
        o_stat.cnt_zero      = (r_count == '0);
        o_stat.cnt_full      = (r_count >= CNT_W'(CAPACITY));
        o_stat.pos_gt_cnt    = (r_pos > r_count);
        o_stat.pos_eq_cnt    = (r_pos == r_count);
        o_stat.pos_ge_cnt    = (r_pos >= r_count);
        o_stat.pos_p1_eq_cnt = ((r_pos + POS_W'(1)) == r_count);
        o_stat.ptr_eq_pos    = ({1'b0, r_ptr} == r_pos);
        o_stat.ptr_eq_cnt_m1 = ({1'b0, r_ptr} == cnt_m1);
        o_stat.rd_valid      = r_rv;
        o_stat.rd_match      = ($signed(rdata) == r_value);
        o_stat.rd_last       = ({1'b0, r_ra} == cnt_m1);
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_found_index = r_idx;
    assign o_data        = r_data;
    assign o_last        = r_last;

endmodule

[hdl/iads_ctrl.sv]
// Controller state machine: decodes each command and sequences the datapath.
// Depends on iads_pkg.
`timescale 1ns / 1ps

module iads_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  iads_pkg::t_dp_stat i_stat,
    output iads_pkg::t_dp_cmd  o_cmd
);
    import iads_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_DRAIN,
        S_INS_VAL,
        S_DEL_RD,
        S_DEL_DRAIN,
        S_SCAN,
        S_SCAN_TAIL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    // Helper for the final result of a command: emit with the given status and last set.
    function automatic t_dp_cmd finish(input t_dp_cmd c, input t_status s);
        t_dp_cmd r;
        r             = c;
        r.emit        = 1'b1;
        r.emit_status = s;
        r.emit_last   = 1'b1;
        return r;
    endfunction

    always_comb begin
        o_cmd              = '0;
        o_cmd.ptr_op       = PTR_HOLD;
        o_cmd.wr_op        = WR_NONE;
        o_cmd.cnt_op       = CNT_HOLD;
        o_cmd.emit_status  = ST_OK;
        n_state            = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && !r_busy) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_stat.cmd)
                    CMD_CLEAR: begin
                        o_cmd        = finish(o_cmd, ST_OK);
                        o_cmd.cnt_op = CNT_CLR;
                    end
                    CMD_INSERT: begin
                        if (i_stat.cnt_full) begin
                            o_cmd = finish(o_cmd, ST_FULL);
                        end else if (i_stat.pos_gt_cnt) begin
                            o_cmd = finish(o_cmd, ST_BADINDEX);
                        end else if (i_stat.pos_eq_cnt) begin
                            n_state = S_INS_VAL;
                        end else begin
                            o_cmd.ptr_op = PTR_CNT_M1;
                            n_state      = S_INS_RD;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd = finish(o_cmd, ST_EMPTY);
                        end else if (i_stat.pos_ge_cnt) begin
                            o_cmd = finish(o_cmd, ST_BADINDEX);
                        end else if (i_stat.pos_p1_eq_cnt) begin
                            o_cmd        = finish(o_cmd, ST_OK);
                            o_cmd.cnt_op = CNT_DEC;
                        end else begin
                            o_cmd.ptr_op = PTR_POS_P1;
                            n_state      = S_DEL_RD;
                        end
                    end
                    CMD_SEARCH, CMD_DUMP: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd = finish(o_cmd, ST_EMPTY);
                        end else begin
                            o_cmd.ptr_op = PTR_ZERO;
                            n_state      = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd = finish(o_cmd, ST_BADCMD);
                    end
                endcase
            end
            S_INS_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.ptr_op = PTR_DEC;
                if (i_stat.rd_valid) begin
                    o_cmd.wr_op = WR_UP;
                end
                if (i_stat.ptr_eq_pos) begin
                    n_state = S_INS_DRAIN;
                end
            end
            S_INS_DRAIN: begin
                o_cmd.wr_op = WR_UP;
                n_state     = S_INS_VAL;
            end
            S_INS_VAL: begin
                o_cmd        = finish(o_cmd, ST_OK);
                o_cmd.wr_op  = WR_VALUE;
                o_cmd.cnt_op = CNT_INC;
                n_state      = S_IDLE;
            end
            S_DEL_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.ptr_op = PTR_INC;
                if (i_stat.rd_valid) begin
                    o_cmd.wr_op = WR_DOWN;
                end
                if (i_stat.ptr_eq_cnt_m1) begin
                    n_state = S_DEL_DRAIN;
                end
            end
            S_DEL_DRAIN: begin
                o_cmd        = finish(o_cmd, ST_OK);
                o_cmd.wr_op  = WR_DOWN;
                o_cmd.cnt_op = CNT_DEC;
                n_state      = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.cmd == CMD_SEARCH && i_stat.rd_valid && i_stat.rd_match) begin
                    o_cmd             = finish(o_cmd, ST_OK);
                    o_cmd.emit_rd_idx = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.ptr_op = PTR_INC;
                    if (i_stat.cmd == CMD_DUMP && i_stat.rd_valid) begin
                        o_cmd.emit         = 1'b1;
                        o_cmd.emit_status  = ST_OK;
                        o_cmd.emit_last    = i_stat.rd_last;
                        o_cmd.emit_rd_idx  = 1'b1;
                        o_cmd.emit_rd_data = 1'b1;
                    end
                    if (i_stat.ptr_eq_cnt_m1) begin
                        n_state = S_SCAN_TAIL;
                    end
                end
            end
            S_SCAN_TAIL: begin
                n_state = S_IDLE;
                if (i_stat.cmd == CMD_DUMP) begin
                    o_cmd              = finish(o_cmd, ST_OK);
                    o_cmd.emit_rd_idx  = 1'b1;
                    o_cmd.emit_rd_data = 1'b1;
                end else if (i_stat.rd_match) begin
                    o_cmd             = finish(o_cmd, ST_OK);
                    o_cmd.emit_rd_idx = 1'b1;
                end else begin
                    o_cmd = finish(o_cmd, ST_NOTFOUND);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy = r_busy;

endmodule

[hdl/iads_checker.sv]
// Port-level assertions for the ordered-list block, bound to its top level.
// Depends on iads_pkg and indexed_array_insert_delete_search.
`timescale 1ns / 1ps

module iads_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic [iads_pkg::STAT_W-1:0] o_status,
    input logic                        o_last
);
    import iads_pkg::*;

    // A result only comes out of a transaction in progress.
    a_strobe_in_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transaction");

    // A dump streams without gaps until its final result.
    a_dump_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap in a multi-result transaction");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> (o_strobe && o_last))
        else $error("busy fell without the final result");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_OK)) |-> o_last)
        else $error("error result not marked as final");

endmodule

bind indexed_array_insert_delete_search iads_checker u_iads_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_status(o_status),
    .o_last  (o_last)
);
